// ----- rtl/pku_pkg.sv -----
// Shared types and constants for the packed 10-bit pixel unpacker.
`default_nettype none
package pku_pkg;

  localparam int WORD_W   = 32;
  localparam int SAMPLE_W = 10;
  localparam int PER_WORD = 3;
  localparam int MAX_WIDTH = 4096;
  localparam int ROWS_MAX  = 4096;

  // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 32768.
  localparam int DIV3_MUL   = 21846;
  localparam int DIV3_SHIFT = 16;

  typedef enum logic [1:0] {
    REG_START_PIXEL  = 2'd0,
    REG_WIDTH_PIXELS = 2'd1,
    REG_ROW_COUNT    = 2'd2,
    REG_MODE         = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_LUMA10 = 2'd0,
    MODE_LUMA8  = 2'd1,
    MODE_CHROMA = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  // Window geometry derived from the configuration registers.
  typedef struct packed {
    logic [11:0] xs;       // first window column
    logic [12:0] xe;       // one past the last window column
    logic [12:0] xe_m1;    // last window column
    logic [10:0] g0;       // word group holding the first column
    logic [12:0] wpr;      // words per row
    logic [11:0] rows_m1;  // index of the last row
    logic        chroma;
    logic        luma8;
    logic        ready;    // derived values are consistent with the registers
  } cfg_t;

  // One result slot of a word.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                plane;
    logic                row_end;
    logic                frame_end;
  } slot_t;

endpackage
`default_nettype wire

// ----- rtl/pku_cfg.sv -----
// Configuration registers and the window geometry derived from them.
`default_nettype none
module pku_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [12:0]   wr_data,
  output pku_pkg::cfg_t      cfg
);

  logic [11:0] start_pixel_r;
  logic [12:0] width_pixels_r;
  logic [12:0] row_count_r;
  logic [1:0]  mode_r;
  logic [1:0]  wait_r;
  logic [1:0]  wait_nxt;

  logic [12:0] w_sat;
  logic [12:0] rows_sat;
  logic [12:0] xe;
  logic [13:0] xe_p2;
  logic        chroma;

  logic [26:0] prod_g0_r;
  logic [28:0] prod_ge_r;
  logic [10:0] g0_r;
  logic [12:0] wpr_r;
  logic [11:0] groups;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pixel_r  <= '0;
      width_pixels_r <= 13'd1;
      row_count_r    <= 13'd1;
      mode_r         <= pku_pkg::MODE_LUMA10;
    end else if (wr_en) begin
      case (pku_pkg::reg_idx_t'(wr_index))
        pku_pkg::REG_START_PIXEL:  start_pixel_r  <= wr_data[11:0];
        pku_pkg::REG_WIDTH_PIXELS: width_pixels_r <= wr_data;
        pku_pkg::REG_ROW_COUNT:    row_count_r    <= wr_data;
        pku_pkg::REG_MODE:         mode_r         <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // Two pipeline stages derive the geometry, so a write holds off words until both have refilled.
  always_comb begin
    wait_nxt = wait_r;
    if (wr_en) begin
      wait_nxt = 2'd2;
    end else if (wait_r != 2'd0) begin
      wait_nxt = wait_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= 2'd2;
    end else begin
      wait_r <= wait_nxt;
    end
  end

  always_comb begin
    if (width_pixels_r == 13'd0) begin
      w_sat = 13'd1;
    end else if (width_pixels_r > 13'(pku_pkg::MAX_WIDTH)) begin
      w_sat = 13'(pku_pkg::MAX_WIDTH);
    end else begin
      w_sat = width_pixels_r;
    end
    if (row_count_r == 13'd0) begin
      rows_sat = 13'd1;
    end else if (row_count_r > 13'(pku_pkg::ROWS_MAX)) begin
      rows_sat = 13'(pku_pkg::ROWS_MAX);
    end else begin
      rows_sat = row_count_r;
    end
    xe     = {1'b0, start_pixel_r} + w_sat;
    xe_p2  = {1'b0, xe} + 14'd2;
    chroma = (mode_r == pku_pkg::MODE_CHROMA);
  end

  // Stage one: the two divisions by three as reciprocal products.
  always_ff @(posedge clk) begin
    prod_g0_r <= start_pixel_r * 15'(pku_pkg::DIV3_MUL);
    prod_ge_r <= xe_p2 * 15'(pku_pkg::DIV3_MUL);
  end

  assign groups = prod_ge_r[27:16] - {1'b0, prod_g0_r[26:16]};

  // Stage two: group count and words per row.
  always_ff @(posedge clk) begin
    g0_r  <= prod_g0_r[26:16];
    wpr_r <= chroma ? {groups, 1'b0} : {1'b0, groups};
  end

  always_comb begin
    cfg.xs      = start_pixel_r;
    cfg.xe      = xe;
    cfg.xe_m1   = xe - 13'd1;
    cfg.g0      = g0_r;
    cfg.wpr     = wpr_r;
    cfg.rows_m1 = 12'(rows_sat - 13'd1);
    cfg.chroma  = chroma;
    cfg.luma8   = (mode_r == pku_pkg::MODE_LUMA8);
    cfg.ready   = (wait_r == 2'd0);
  end

endmodule
`default_nettype wire

// ----- rtl/pku_word.sv -----
// Word stage: position counters, slot selection and the registered slot bundle.
`default_nettype none
module pku_word (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pku_pkg::cfg_t         cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [31:0]           in_word,
  input  wire logic [2:0]            pop,
  output logic [2:0]                 mask,
  output pku_pkg::slot_t [2:0]       slots
);

  logic [12:0] word_in_row_r;
  logic [12:0] word_in_row_nxt;
  logic [11:0] row_index_r;
  logic [11:0] row_index_nxt;
  logic [2:0]  mask_r;
  logic [2:0]  mask_nxt;
  logic [2:0]  remaining;
  pku_pkg::slot_t [2:0] slots_r;
  pku_pkg::slot_t [2:0] slots_nxt;
  logic [2:0]  keep;

  logic        accept;
  logic        last_row;
  logic [12:0] k_step;
  logic [13:0] grp;
  logic [14:0] base_col;
  logic [13:0] k_inc;

  assign remaining = mask_r & ~pop;
  assign in_ready  = cfg.ready && (remaining == 3'b000);
  assign accept    = in_valid && in_ready;
  assign last_row  = (row_index_r >= cfg.rows_m1);
  assign k_step    = cfg.chroma ? {1'b0, word_in_row_r[12:1]} : word_in_row_r;
  assign grp       = {3'b000, cfg.g0} + {1'b0, k_step};
  assign base_col  = {grp, 1'b0} + {1'b0, grp};
  assign k_inc     = {1'b0, word_in_row_r} + 14'd1;

  for (genvar j = 0; j < pku_pkg::PER_WORD; j++) begin : g_slot
    logic [9:0]  raw;
    logic [1:0]  off;
    logic        pl;
    logic [14:0] col;
    logic        last;

    assign raw = in_word[10*j +: 10];

    // Chroma words interleave U and V: even words U0 V0 U1, odd words V1 U2 V2.
    always_comb begin
      if (!cfg.chroma) begin
        off = 2'(j);
        pl  = 1'b0;
      end else if (!word_in_row_r[0]) begin
        off = (j == 2) ? 2'd1 : 2'd0;
        pl  = (j == 1);
      end else begin
        off = (j == 0) ? 2'd1 : 2'd2;
        pl  = (j != 1);
      end
    end

    assign col  = base_col + {13'd0, off};
    assign last = (col == {2'b00, cfg.xe_m1}) && (!cfg.chroma || pl);
    assign keep[j] = (col >= {3'b000, cfg.xs}) && (col < {2'b00, cfg.xe});

    always_comb begin
      slots_nxt[j].sample    = cfg.luma8 ? {2'b00, raw[9:2]} : raw;
      slots_nxt[j].plane     = pl;
      slots_nxt[j].row_end   = last;
      slots_nxt[j].frame_end = last && last_row;
    end
  end

  always_comb begin
    word_in_row_nxt = word_in_row_r;
    row_index_nxt   = row_index_r;
    mask_nxt        = remaining;
    if (accept) begin
      mask_nxt = keep;
      if (k_inc >= {1'b0, cfg.wpr}) begin
        word_in_row_nxt = '0;
        row_index_nxt   = last_row ? 12'd0 : row_index_r + 12'd1;
      end else begin
        word_in_row_nxt = k_inc[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_in_row_r <= '0;
      row_index_r   <= '0;
      mask_r        <= '0;
    end else begin
      word_in_row_r <= word_in_row_nxt;
      row_index_r   <= row_index_nxt;
      mask_r        <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots_r <= slots_nxt;
    end
  end

  assign mask  = mask_r;
  assign slots = slots_r;

endmodule
`default_nettype wire

// ----- rtl/pku_out.sv -----
// Result stage: picks the next pending slot and holds it in the output register.
`default_nettype none
module pku_out (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2:0]            mask,
  input  wire pku_pkg::slot_t [2:0]  slots,
  output logic [2:0]                 pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pku_pkg::slot_t             out_slot
);

  logic           out_valid_r;
  pku_pkg::slot_t out_slot_r;
  pku_pkg::slot_t pick_slot;
  logic [2:0]     first;
  logic           load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    first     = 3'b000;
    pick_slot = slots[0];
    if (mask[0]) begin
      first = 3'b001;
    end else if (mask[1]) begin
      first     = 3'b010;
      pick_slot = slots[1];
    end else if (mask[2]) begin
      first     = 3'b100;
      pick_slot = slots[2];
    end
  end

  assign pop = load ? first : 3'b000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= (mask != 3'b000);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r <= pick_slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;

endmodule
`default_nettype wire

// ----- rtl/packed_10bit_pixel_unpacker.sv -----
// Top level of the packed 10-bit pixel unpacker.
//
//  Channel  Direction  Ports                                   Content
//  cfg      in         cfg_valid/ready, cfg_index, cfg_data    register write request
//  in       in         in_valid/ready, in_packed_word          one source word
//  out      out        out_valid/ready, out_sample, out_plane, one kept sample and its
//                      out_row_end, out_frame_end              row and window end marks
//
// A word's zero to three kept samples leave one per cycle while the output is ready, so a
// full word is paced by the one-sample result port. A new word enters in the cycle its last
// sample moves to the output register. Reset is synchronous and active low; after reset and
// after every register write the input stalls while the window geometry is rederived. A
// stalled output holds its request, and the input waits while any sample of the previous
// word has not reached the output register.
`default_nettype none
module packed_10bit_pixel_unpacker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_packed_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_sample,
  output logic             out_plane,
  output logic             out_row_end,
  output logic             out_frame_end
);

  pku_pkg::cfg_t             cfg;
  pku_pkg::slot_t [2:0]      slots;
  pku_pkg::slot_t            out_slot;
  logic [2:0]                mask;
  logic [2:0]                pop;

  // Register writes are always taken; the geometry pipeline absorbs them.
  assign cfg_ready = 1'b1;

  pku_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The word stage works out which of the three samples fall inside the window and
  // how each is marked, then holds them until the result stage has drained them.
  pku_word u_word (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_packed_word),
    .pop      (pop),
    .mask     (mask),
    .slots    (slots)
  );

  pku_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .mask      (mask),
    .slots     (slots),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_slot  (out_slot)
  );

  assign out_sample    = out_slot.sample;
  assign out_plane     = out_slot.plane;
  assign out_row_end   = out_slot.row_end;
  assign out_frame_end = out_slot.frame_end;

endmodule
`default_nettype wire

// ----- tb/packed_10bit_pixel_unpacker_tb.sv -----
// Self-checking testbench for the packed 10-bit pixel unpacker.
`timescale 1ns / 1ps
module packed_10bit_pixel_unpacker_tb;

  // The scoreboard keeps its own copy of the window registers and of the row and word
  // counters. Every source word the block accepts is unpacked here into the samples
  // the block must emit, and each sample leaving the block is compared with the oldest
  // of them.
  class window_sample_scoreboard;
    logic [11:0]     xs_reg;
    logic [12:0]     width_reg;
    logic [12:0]     rows_reg;
    pku_pkg::mode_t  mode_reg;
    logic [12:0]     word_pos;
    logic [11:0]     row_pos;
    int unsigned     win_first, win_end, first_group, row_words, row_total;
    bit              chroma;
    pku_pkg::slot_t  expected_samples[$];
    int unsigned     failures;

    function new();
      xs_reg    = '0;
      width_reg = 13'd1;
      rows_reg  = 13'd1;
      mode_reg  = pku_pkg::MODE_LUMA10;
      word_pos  = '0;
      row_pos   = '0;
      failures  = 0;
      update_geometry();
    endfunction

    // Zero width and zero rows count as one; anything above the maximum is clipped.
    function void update_geometry();
      int unsigned w;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > pku_pkg::MAX_WIDTH) w = pku_pkg::MAX_WIDTH;
      row_total = (rows_reg == 0) ? 1 : rows_reg;
      if (row_total > pku_pkg::ROWS_MAX) row_total = pku_pkg::ROWS_MAX;
      chroma      = (mode_reg == pku_pkg::MODE_CHROMA);
      win_first   = xs_reg;
      win_end     = win_first + w;
      first_group = win_first / pku_pkg::PER_WORD;
      row_words   = (win_end + pku_pkg::PER_WORD - 1) / pku_pkg::PER_WORD - first_group;
      if (chroma) row_words = 2 * row_words;
    endfunction

    // Counters are deliberately left alone: a write in the middle of a window takes
    // effect on the very next word.
    function void set_reg(pku_pkg::reg_idx_t idx, logic [12:0] data);
      case (idx)
        pku_pkg::REG_START_PIXEL:  xs_reg    = data[11:0];
        pku_pkg::REG_WIDTH_PIXELS: width_reg = data;
        pku_pkg::REG_ROW_COUNT:    rows_reg  = data;
        pku_pkg::REG_MODE:         mode_reg  = pku_pkg::mode_t'(data[1:0]);
        default: ;
      endcase
      update_geometry();
    endfunction

    // Words still needed to close the current window under the present settings.
    function int unsigned words_left();
      int unsigned rem;
      rem = (word_pos >= row_words) ? 1 : row_words - word_pos;
      if (row_pos + 1 >= row_total) return rem;
      return rem + (row_total - 1 - row_pos) * row_words;
    endfunction

    function int unsigned pending();
      return expected_samples.size();
    endfunction

    function void note_word(logic [31:0] word);
      int unsigned k, grp, s, col;
      logic [pku_pkg::SAMPLE_W-1:0] raw;
      bit last_row, last;
      pku_pkg::slot_t r;
      k        = word_pos;
      grp      = first_group + (chroma ? (k >> 1) : k);
      last_row = (row_pos + 1 >= row_total);
      for (int j = 0; j < pku_pkg::PER_WORD; j++) begin
        raw = word[pku_pkg::SAMPLE_W*j +: pku_pkg::SAMPLE_W];
        if (chroma) begin
          // Two words carry three U,V pairs: U0 V0 U1 | V1 U2 V2.
          s       = (k & 1) * pku_pkg::PER_WORD + j;
          col     = pku_pkg::PER_WORD * grp + (s >> 1);
          r.plane = s[0];
          last    = (col == win_end - 1) && s[0];
        end else begin
          col     = pku_pkg::PER_WORD * grp + j;
          r.plane = 1'b0;
          last    = (col == win_end - 1);
        end
        if (col >= win_first && col < win_end) begin
          r.sample    = (mode_reg == pku_pkg::MODE_LUMA8) ? {2'b00, raw[9:2]} : raw;
          r.row_end   = last;
          r.frame_end = last && last_row;
          expected_samples.push_back(r);
        end
      end
      if (k + 1 >= row_words) begin
        word_pos = '0;
        row_pos  = last_row ? 12'd0 : row_pos + 12'd1;
      end else begin
        word_pos = 13'(k + 1);
      end
    endfunction

    function void check_sample(logic [9:0] smp, logic pl, logic re, logic fe);
      pku_pkg::slot_t e;
      if (expected_samples.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected sample %0d plane %0d row_end %0d frame_end %0d",
                   $time, smp, pl, re, fe);
        return;
      end
      e = expected_samples.pop_front();
      if (smp !== e.sample || pl !== e.plane || re !== e.row_end || fe !== e.frame_end) begin
        failures++;
        if (failures <= 10)
          $display({"%0t: mismatch expected sample %0d plane %0d row_end %0d frame_end %0d,",
                    " got %0d %0d %0d %0d"},
                   $time, e.sample, e.plane, e.row_end, e.frame_end, smp, pl, re, fe);
      end
    endfunction
  endclass

  localparam int unsigned N_WORDS = 170;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_packed_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_sample;
  logic        out_plane;
  logic        out_row_end;
  logic        out_frame_end;

  // When set, neither side inserts gaps, so the block runs at its full rate.
  bit no_idle = 1'b0;

  // Source words accepted by the block so far.
  int unsigned words_sent = 0;

  window_sample_scoreboard sb = new();

  always #10 clk = ~clk;

  packed_10bit_pixel_unpacker DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_packed_word(in_packed_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample    (out_sample),
    .out_plane     (out_plane),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  // Every sample taken by the sink is checked at the edge on which it is accepted.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_sample(out_sample, out_plane, out_row_end, out_frame_end);
  end

  // Sink: before each request it may hold ready low for a random number of cycles.
  // Ready is lowered and raised on different falling edges, never in the same step.
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Sends one source word. Valid stays high straight into the next request when no gap
  // is drawn, so it is only lowered when there really is an idle cycle to show.
  task automatic send_word(logic [31:0] word);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_word <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_word(word);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(pku_pkg::reg_idx_t idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Waits until every expected sample is out, then a little longer, since a word that
  // keeps no samples may still be passing through the block.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Reprogrammes the whole window once the block has gone quiet.
  task automatic set_window(logic [12:0] xs, logic [12:0] w, logic [12:0] rows,
                            pku_pkg::mode_t md);
    drain();
    no_idle = ($urandom_range(0, 3) == 0);
    write_reg(pku_pkg::REG_START_PIXEL, xs);
    write_reg(pku_pkg::REG_WIDTH_PIXELS, w);
    write_reg(pku_pkg::REG_ROW_COUNT, rows);
    write_reg(pku_pkg::REG_MODE, {11'd0, md});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned left;
    int unsigned n;
    logic [12:0] xs, w, rows;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: a one-pixel window, so every word yields one sample marking both ends.
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);

    // Largest start column with a width above the maximum and zero rows, in 8-bit mode.
    // Only the first few words of the very long row are sent.
    set_window(13'h1fff, 13'h1fff, 13'd0, pku_pkg::MODE_LUMA8);
    send_word(32'hffff_ffff);
    send_word(32'hc00f_fc03);
    send_word(32'h2aaa_aaaa);

    // Narrowing the window mid-row: the word counter is now past the row's word count, so the
    // next word lies outside the window and keeps no samples, but it still closes the row and the window.
    set_window(13'd0, 13'd1, 13'd1, pku_pkg::MODE_LUMA10);
    send_word(32'h1555_5555);

    // Chroma pairs over two rows. The first word of each row keeps no samples at all.
    set_window(13'd2, 13'd2, 13'd2, pku_pkg::MODE_CHROMA);
    repeat (8) send_word(rand_word());

    // The spare mode code behaves as 10-bit luma; the window sits inside one word.
    set_window(13'd1, 13'd1, 13'd3, pku_pkg::MODE_SPARE);
    repeat (3) send_word(rand_word());

    // Row count above the maximum; the window is left open for the random part.
    set_window(13'd0, 13'd3, 13'h1fff, pku_pkg::MODE_LUMA10);
    send_word(32'h3ff0_03ff);
    send_word(32'h000f_fc00);

    // Random windows. Most are run to their end so that whole frames are seen; large
    // ones, and now and then a small one, are cut short, which also exercises register
    // writes with the counters in the middle of a window.
    while (words_sent < N_WORDS) begin
      xs = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                       : 13'($urandom_range(0, 20));
      case ($urandom_range(0, 9))
        0:       w = 13'd0;
        1:       w = 13'($urandom_range(4000, 8191));
        default: w = 13'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 9))
        0:       rows = 13'd0;
        1:       rows = 13'($urandom_range(4096, 8191));
        default: rows = 13'($urandom_range(1, 4));
      endcase
      set_window(xs, w, rows, pku_pkg::mode_t'($urandom_range(0, 3)));
      left = sb.words_left();
      if (left > 40 || $urandom_range(0, 5) == 0)
        n = $urandom_range(1, 12);
      else
        n = left;
      if (n > N_WORDS - words_sent) n = N_WORDS - words_sent;
      repeat (n) send_word(rand_word());
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Guard against a hung handshake; well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
